/* sv/multi_pass_best_candidate_select_core_macros.svh */
// Assertion macros shared by the best candidate select RTL.
`ifndef MULTI_PASS_BEST_CANDIDATE_SELECT_CORE_MACROS_SVH
`define MULTI_PASS_BEST_CANDIDATE_SELECT_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define MPBCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define MPBCS_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define MPBCS_ASSERT(name, prop, msg)

`define MPBCS_ASSERT_NEVER(name, cond, msg)

`endif

`endif

/* sv/mpbcs_pkg.sv */
// Types and constants of the best candidate select core.
`default_nettype none

package mpbcs_pkg;

  localparam int STORE_W = 56;
  localparam int THR_W   = 48;
  localparam int PROD_W  = 48;
  localparam int RAW_W   = 32;
  localparam int WGT_W   = 16;
  localparam int CAND_W  = 6;
  localparam int PASS_W  = 2;
  localparam int CNT_W   = 7;
  localparam int PCNT_W  = 3;
  localparam int NUM_THR = 4;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 6;

  typedef enum logic [2:0] {
    REG_PASS_COUNT = 3'd0,
    REG_THR0       = 3'd1,
    REG_THR1       = 3'd2,
    REG_THR2       = 3'd3,
    REG_THR3       = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD_WR,
    ST_FIND_RD,
    ST_FIND_EV,
    ST_FIND_END,
    ST_PRUNE_RD,
    ST_PRUNE_EV,
    ST_PRUNE_END
  } state_t;

  typedef enum logic [1:0] {
    ALU_ACC,
    ALU_GT,
    ALU_GAP
  } alu_op_t;

  typedef struct packed {
    logic [STORE_W-1:0] sum;
    logic               gt;
    logic               exceed;
  } alu_res_t;

endpackage

`default_nettype wire

/* sv/mpbcs_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none

module mpbcs_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* sv/mpbcs_alu.sv */
// Shared 56-bit add/subtract unit: saturating accumulate, compare, gap test.
`default_nettype none

module mpbcs_alu (
  input  wire mpbcs_pkg::alu_op_t                 op,
  input  wire logic [mpbcs_pkg::STORE_W-1:0]      a,
  input  wire logic [mpbcs_pkg::STORE_W-1:0]      b,
  input  wire logic [mpbcs_pkg::THR_W-1:0]        thr,
  output mpbcs_pkg::alu_res_t                     res
);

  localparam int W = mpbcs_pkg::STORE_W;

  logic [W:0] a_ext;
  logic [W:0] b_ext;
  logic [W:0] raw;
  logic       cin;

  always_comb begin
    a_ext = {a[W-1], a};
    cin   = (op != mpbcs_pkg::ALU_ACC);
    b_ext = cin ? ~{b[W-1], b} : {b[W-1], b};
    raw   = a_ext + b_ext + (W+1)'(cin);
    if (raw[W] != raw[W-1]) begin
      res.sum = raw[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      res.sum = raw[W-1:0];
    end
    res.gt     = !raw[W] && (raw != '0);
    res.exceed = raw > (W+1)'(thr);
  end

endmodule

`default_nettype wire

/* sv/multi_pass_best_candidate_select_core.sv */
// Top level of the multi-pass best candidate select core.
// Load word: a store read, then a saturating add and write back.
// Last word: the same load, then per pass a find walk and, on all but the last pass, a
// prune walk over MAX_CANDIDATES indexes (read state, evaluate state for survivors).
// Result strobe done is raised as a store clear over all MAX_CANDIDATES*MAX_PASSES words begins.
// Reset runs that same clear sweep with busy high; control registers take their reset values.
`default_nettype none

module multi_pass_best_candidate_select_core #(
  parameter int MAX_CANDIDATES = 64,
  parameter int MAX_PASSES     = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [mpbcs_pkg::CAND_W-1:0]       candidate,
  input  wire logic [mpbcs_pkg::PASS_W-1:0]       pass_number,
  input  wire logic signed [mpbcs_pkg::RAW_W-1:0] raw_score,
  input  wire logic signed [mpbcs_pkg::WGT_W-1:0] weight,
  input  wire logic [mpbcs_pkg::CNT_W-1:0]        candidate_count,
  input  wire logic                               last,
  output logic                                    done,
  output logic                                    found,
  output logic [mpbcs_pkg::CAND_W-1:0]            winner,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mpbcs_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [mpbcs_pkg::DATA_W-1:0]       pwdata,
  output logic [mpbcs_pkg::DATA_W-1:0]            prdata,
  output logic                                    pready
);

`include "multi_pass_best_candidate_select_core_macros.svh"

  localparam int DEPTH = MAX_CANDIDATES * MAX_PASSES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_CANDIDATES);
  localparam int PW    = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;
  localparam int NW    = $clog2(MAX_CANDIDATES + 1);
  localparam int PCW   = $clog2(MAX_PASSES + 1);
  localparam int SW    = mpbcs_pkg::STORE_W;
  localparam int TW    = mpbcs_pkg::THR_W;
  localparam int XW    = mpbcs_pkg::PROD_W;

  localparam logic [CW-1:0] LAST_CAND = CW'(MAX_CANDIDATES - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  localparam logic [1:0] LEFT_NONE = 2'd0;
  localparam logic [1:0] LEFT_ONE  = 2'd1;
  localparam logic [1:0] LEFT_MANY = 2'd2;

  mpbcs_pkg::state_t state, state_next;

  logic [AW-1:0]             clr_addr, clr_addr_next;
  logic [AW-1:0]             ld_addr, ld_addr_next;
  logic                      ld_we, ld_we_next;
  logic                      ld_last, ld_last_next;
  logic [NW-1:0]             ld_count, ld_count_next;
  logic signed [XW-1:0]      product, product_next;
  logic [MAX_CANDIDATES-1:0] survivor, survivor_next;
  logic [CW-1:0]             idx, idx_next;
  logic [PW-1:0]             pass_idx, pass_idx_next;
  logic                      have, have_next;
  logic [CW-1:0]             best, best_next;
  logic [SW-1:0]             best_score, best_score_next;
  logic [1:0]                left, left_next;
  logic [CW-1:0]             first, first_next;
  logic                      done_next;
  logic                      found_next;
  logic [mpbcs_pkg::CAND_W-1:0] winner_next;

  logic [mpbcs_pkg::PCNT_W-1:0] pass_count;
  logic [TW-1:0]                thr [mpbcs_pkg::NUM_THR];

  logic                 in_range;
  logic [NW-1:0]        n_sat;
  logic [PCW-1:0]       passes_sat;
  logic                 last_pass;
  logic [TW-1:0]        thr_sel;
  logic [AW-1:0]        walk_addr;

  logic                 ram_we;
  logic [AW-1:0]        ram_addr;
  logic [SW-1:0]        ram_wdata;
  logic [SW-1:0]        rdata;

  mpbcs_pkg::alu_op_t   alu_op;
  logic [SW-1:0]        alu_a;
  logic [SW-1:0]        alu_b;
  mpbcs_pkg::alu_res_t  alu_res;

  logic                 cfg_wr;

  mpbcs_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  mpbcs_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .thr (thr_sel),
    .res (alu_res)
  );

  assign busy   = (state != mpbcs_pkg::ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    in_range = (32'(candidate) < MAX_CANDIDATES) && (32'(pass_number) < MAX_PASSES);
    n_sat = (32'(candidate_count) > MAX_CANDIDATES) ? NW'(MAX_CANDIDATES)
                                                     : NW'(candidate_count);
    passes_sat = (32'(pass_count) > MAX_PASSES) ? PCW'(MAX_PASSES) : PCW'(pass_count);
    last_pass  = (32'(pass_idx) + 1 == 32'(passes_sat));
    thr_sel    = (32'(pass_idx) < mpbcs_pkg::NUM_THR) ? thr[2'(pass_idx)] : '0;
    walk_addr  = AW'(32'(idx) * MAX_PASSES + 32'(pass_idx));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpbcs_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    ld_addr_next    = ld_addr;
    ld_we_next      = ld_we;
    ld_last_next    = ld_last;
    ld_count_next   = ld_count;
    product_next    = product;
    survivor_next   = survivor;
    idx_next        = idx;
    pass_idx_next   = pass_idx;
    have_next       = have;
    best_next       = best;
    best_score_next = best_score;
    left_next       = left;
    first_next      = first;
    done_next       = 1'b0;
    found_next      = found;
    winner_next     = winner;
    ram_we          = 1'b0;
    ram_addr        = walk_addr;
    ram_wdata       = alu_res.sum;
    alu_op          = mpbcs_pkg::ALU_GT;
    alu_a           = rdata;
    alu_b           = best_score;

    unique case (state)
      mpbcs_pkg::ST_CLEAR: begin
        ram_addr  = clr_addr;
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (clr_addr == LAST_ADDR) begin
          state_next = mpbcs_pkg::ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end

      mpbcs_pkg::ST_IDLE: begin
        ram_addr = AW'(32'(candidate) * MAX_PASSES + 32'(pass_number));
        if (start) begin
          ld_addr_next  = ram_addr;
          ld_we_next    = in_range;
          ld_last_next  = last;
          ld_count_next = n_sat;
          product_next  = raw_score * weight;
          state_next    = mpbcs_pkg::ST_LOAD_WR;
        end
      end

      mpbcs_pkg::ST_LOAD_WR: begin
        alu_op   = mpbcs_pkg::ALU_ACC;
        alu_a    = rdata;
        alu_b    = SW'(product);
        ram_addr = ld_addr;
        ram_we   = ld_we;
        if (!ld_last) begin
          state_next = mpbcs_pkg::ST_IDLE;
        end else begin
          for (int i = 0; i < MAX_CANDIDATES; i++) begin
            survivor_next[i] = (i < int'(ld_count));
          end
          idx_next      = '0;
          pass_idx_next = '0;
          have_next     = 1'b0;
          if (passes_sat == '0) begin
            found_next    = (ld_count != '0);
            winner_next   = '0;
            done_next     = 1'b1;
            clr_addr_next = '0;
            state_next    = mpbcs_pkg::ST_CLEAR;
          end else begin
            state_next = mpbcs_pkg::ST_FIND_RD;
          end
        end
      end

      mpbcs_pkg::ST_FIND_RD: begin
        if (survivor[idx]) begin
          state_next = mpbcs_pkg::ST_FIND_EV;
        end else if (idx == LAST_CAND) begin
          state_next = mpbcs_pkg::ST_FIND_END;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      mpbcs_pkg::ST_FIND_EV: begin
        alu_op = mpbcs_pkg::ALU_GT;
        alu_a  = rdata;
        alu_b  = best_score;
        if (!have || alu_res.gt) begin
          have_next       = 1'b1;
          best_next       = idx;
          best_score_next = rdata;
        end
        if (idx == LAST_CAND) begin
          state_next = mpbcs_pkg::ST_FIND_END;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = mpbcs_pkg::ST_FIND_RD;
        end
      end

      mpbcs_pkg::ST_FIND_END: begin
        if (!have || last_pass) begin
          found_next    = have;
          winner_next   = have ? 6'(best) : '0;
          done_next     = 1'b1;
          clr_addr_next = '0;
          state_next    = mpbcs_pkg::ST_CLEAR;
        end else begin
          idx_next   = '0;
          left_next  = LEFT_NONE;
          state_next = mpbcs_pkg::ST_PRUNE_RD;
        end
      end

      mpbcs_pkg::ST_PRUNE_RD: begin
        if (survivor[idx]) begin
          state_next = mpbcs_pkg::ST_PRUNE_EV;
        end else if (idx == LAST_CAND) begin
          state_next = mpbcs_pkg::ST_PRUNE_END;
        end else begin
          idx_next = idx + 1'b1;
        end
      end

      mpbcs_pkg::ST_PRUNE_EV: begin
        alu_op = mpbcs_pkg::ALU_GAP;
        alu_a  = best_score;
        alu_b  = rdata;
        if (alu_res.exceed) begin
          survivor_next[idx] = 1'b0;
        end else begin
          if (left == LEFT_NONE) begin
            first_next = idx;
          end
          if (left != LEFT_MANY) begin
            left_next = left + 1'b1;
          end
        end
        if (idx == LAST_CAND) begin
          state_next = mpbcs_pkg::ST_PRUNE_END;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = mpbcs_pkg::ST_PRUNE_RD;
        end
      end

      mpbcs_pkg::ST_PRUNE_END: begin
        if (left == LEFT_ONE) begin
          found_next    = 1'b1;
          winner_next   = 6'(first);
          done_next     = 1'b1;
          clr_addr_next = '0;
          state_next    = mpbcs_pkg::ST_CLEAR;
        end else begin
          pass_idx_next = pass_idx + 1'b1;
          idx_next      = '0;
          have_next     = 1'b0;
          state_next    = mpbcs_pkg::ST_FIND_RD;
        end
      end

      default: begin
        clr_addr_next = '0;
        state_next    = mpbcs_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      survivor <= '0;
      done     <= 1'b0;
      found    <= 1'b0;
      winner   <= '0;
      have     <= 1'b0;
      left     <= LEFT_NONE;
      pass_idx <= '0;
      idx      <= '0;
      ld_we    <= 1'b0;
      ld_last  <= 1'b0;
    end else begin
      clr_addr <= clr_addr_next;
      survivor <= survivor_next;
      done     <= done_next;
      found    <= found_next;
      winner   <= winner_next;
      have     <= have_next;
      left     <= left_next;
      pass_idx <= pass_idx_next;
      idx      <= idx_next;
      ld_we    <= ld_we_next;
      ld_last  <= ld_last_next;
    end
  end

  always_ff @(posedge clk) begin
    ld_addr    <= ld_addr_next;
    ld_count   <= ld_count_next;
    product    <= product_next;
    best       <= best_next;
    best_score <= best_score_next;
    first      <= first_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count <= mpbcs_pkg::PCNT_W'(1);
      for (int i = 0; i < mpbcs_pkg::NUM_THR; i++) begin
        thr[i] <= '0;
      end
    end else if (cfg_wr) begin
      unique case (mpbcs_pkg::reg_idx_t'(paddr[5:3]))
        mpbcs_pkg::REG_PASS_COUNT: pass_count <= pwdata[mpbcs_pkg::PCNT_W-1:0];
        mpbcs_pkg::REG_THR0:       thr[0]     <= pwdata[TW-1:0];
        mpbcs_pkg::REG_THR1:       thr[1]     <= pwdata[TW-1:0];
        mpbcs_pkg::REG_THR2:       thr[2]     <= pwdata[TW-1:0];
        mpbcs_pkg::REG_THR3:       thr[3]     <= pwdata[TW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (mpbcs_pkg::reg_idx_t'(paddr[5:3]))
      mpbcs_pkg::REG_PASS_COUNT: prdata = mpbcs_pkg::DATA_W'(pass_count);
      mpbcs_pkg::REG_THR0:       prdata = mpbcs_pkg::DATA_W'(thr[0]);
      mpbcs_pkg::REG_THR1:       prdata = mpbcs_pkg::DATA_W'(thr[1]);
      mpbcs_pkg::REG_THR2:       prdata = mpbcs_pkg::DATA_W'(thr[2]);
      mpbcs_pkg::REG_THR3:       prdata = mpbcs_pkg::DATA_W'(thr[3]);
      default:                   prdata = '0;
    endcase
  end

  `MPBCS_ASSERT(a_done_in_clear, done |-> (busy && state == mpbcs_pkg::ST_CLEAR), "strobe outside clear")
  `MPBCS_ASSERT_NEVER(a_winner_zero, done && !found && winner != '0, "winner set without find")
  `MPBCS_ASSERT(a_accept_load, (start && !busy) |=> (state == mpbcs_pkg::ST_LOAD_WR), "word not loaded")
  `MPBCS_ASSERT(a_prune_shrinks, (state == mpbcs_pkg::ST_PRUNE_EV) |=> ((survivor & ~$past(survivor)) == '0), "survivor added in prune")

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the multi-pass best candidate select core.
`timescale 1ns / 100ps

module testbench;

  localparam int CAND_W  = mpbcs_pkg::CAND_W;
  localparam int PASS_W  = mpbcs_pkg::PASS_W;
  localparam int RAW_W   = mpbcs_pkg::RAW_W;
  localparam int WGT_W   = mpbcs_pkg::WGT_W;
  localparam int CNT_W   = mpbcs_pkg::CNT_W;
  localparam int THR_W   = mpbcs_pkg::THR_W;
  localparam int STORE_W = mpbcs_pkg::STORE_W;
  localparam int PROD_W  = mpbcs_pkg::PROD_W;
  localparam int NUM_THR = mpbcs_pkg::NUM_THR;
  localparam int ADDR_W  = mpbcs_pkg::ADDR_W;
  localparam int DATA_W  = mpbcs_pkg::DATA_W;

  localparam int SEL_CANDS  = 64;
  localparam int SEL_PASSES = 4;
  localparam int SAT_WORDS  = 530;

  localparam logic [31:0] ONE     = 32'h0001_0000;
  localparam logic [15:0] W1      = 16'h0100;
  localparam logic [47:0] THR_ONE = 48'h0000_0100_0000;
  localparam logic [47:0] THR_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [CAND_W-1:0]        cand;
    logic [PASS_W-1:0]        pidx;
    logic signed [RAW_W-1:0]  raw;
    logic signed [WGT_W-1:0]  wgt;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } score_word_t;

  typedef struct packed {
    logic              found;
    logic [CAND_W-1:0] winner;
  } verdict_t;

  typedef struct packed {
    logic              cfg;
    logic [2:0]        pc;
    logic [THR_W-1:0]  thr;
    logic [CAND_W-1:0] cand;
    logic [PASS_W-1:0] pidx;
    logic [RAW_W-1:0]  raw;
    logic [WGT_W-1:0]  wgt;
    logic [CNT_W-1:0]  count;
    logic              last;
    logic              typed;
    logic              ef;
    logic [CAND_W-1:0] ew;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [CAND_W-1:0] candidate;
  logic [PASS_W-1:0] pass_number;
  logic signed [RAW_W-1:0] raw_score;
  logic signed [WGT_W-1:0] weight;
  logic [CNT_W-1:0] candidate_count;
  logic last;
  logic done;
  logic found;
  logic [CAND_W-1:0] winner;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  logic signed [STORE_W-1:0] score_totals [SEL_CANDS*SEL_PASSES];
  logic [2:0]                pass_cfg;
  logic [THR_W-1:0]          thr_cfg [NUM_THR];
  verdict_t                  pending_verdicts [$];

  int  mismatch_count = 0;
  int  words_sent = 0;
  int  phase_words = 0;
  int  verdicts_seen = 0;
  int  settings_count = 0;
  int  burst_left = 4;
  bit  idle_on = 1'b0;
  bit  start_up = 1'b0;

  dir_row_t dir_rows [19] = '{
    '{1'b0, 3'd0, 48'd0,   6'd5,  2'd0, ONE,           W1,       7'd10,  1'b1, 1'b1, 1'b1, 6'd5},
    '{1'b0, 3'd0, 48'd0,   6'd0,  2'd0, 32'h0,         16'h0,    7'd0,   1'b1, 1'b1, 1'b0, 6'd0},
    '{1'b0, 3'd0, 48'd0,   6'd63, 2'd3, 32'h7FFF_FFFF, 16'h7FFF, 7'd127, 1'b1, 1'b1, 1'b1, 6'd0},
    '{1'b0, 3'd0, 48'd0,   6'd63, 2'd0, 32'h8000_0000, 16'h8000, 7'd127, 1'b1, 1'b1, 1'b1, 6'd63},
    '{1'b0, 3'd0, 48'd0,   6'd62, 2'd0, 32'h7FFF_FFFF, 16'h8000, 7'd64,  1'b1, 1'b1, 1'b1, 6'd0},
    '{1'b1, 3'd0, 48'd0,   6'd7,  2'd0, ONE,           W1,       7'd20,  1'b1, 1'b1, 1'b1, 6'd0},
    '{1'b0, 3'd0, 48'd0,   6'd0,  2'd0, 32'h0,         16'h0,    7'd0,   1'b1, 1'b1, 1'b0, 6'd0},
    '{1'b1, 3'd2, THR_ONE, 6'd2,  2'd0, 32'h0003_0000, W1,       7'd8,   1'b0, 1'b0, 1'b0, 6'd0},
    '{1'b0, 3'd0, 48'd0,   6'd4,  2'd0, 32'h0002_0000, W1,       7'd8,   1'b0, 1'b0, 1'b0, 6'd0},
    '{1'b0, 3'd0, 48'd0,   6'd1,  2'd0, ONE,           W1,       7'd8,   1'b0, 1'b0, 1'b0, 6'd0},
    '{1'b0, 3'd0, 48'd0,   6'd4,  2'd1, ONE,           W1,       7'd8,   1'b1, 1'b0, 1'b0, 6'd0},
    '{1'b0, 3'd0, 48'd0,   6'd2,  2'd0, 32'h0005_0000, W1,       7'd8,   1'b0, 1'b0, 1'b0, 6'd0},
    '{1'b0, 3'd0, 48'd0,   6'd3,  2'd0, ONE,           W1,       7'd8,   1'b1, 1'b0, 1'b0, 6'd0},
    '{1'b1, 3'd7, THR_MAX, 6'd9,  2'd3, ONE,           W1,       7'd16,  1'b0, 1'b0, 1'b0, 6'd0},
    '{1'b0, 3'd0, 48'd0,   6'd9,  2'd2, 32'hFFFF_0000, W1,       7'd16,  1'b1, 1'b0, 1'b0, 6'd0},
    '{1'b1, 3'd4, 48'd0,   6'd0,  2'd0, 32'h0,         16'h0,    7'd64,  1'b1, 1'b0, 1'b0, 6'd0},
    '{1'b1, 3'd3, 48'd0,   6'd10, 2'd1, ONE,           W1,       7'd11,  1'b1, 1'b0, 1'b0, 6'd0},
    '{1'b0, 3'd0, 48'd0,   6'd1,  2'd0, 32'h0000_0001, 16'h8000, 7'd2,   1'b1, 1'b0, 1'b0, 6'd0},
    '{1'b0, 3'd0, 48'd0,   6'd33, 2'd2, 32'h0002_0000, 16'hFF00, 7'd40,  1'b1, 1'b0, 1'b0, 6'd0}
  };

  multi_pass_best_candidate_select_core uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_totals();
    for (int i = 0; i < SEL_CANDS*SEL_PASSES; i++) score_totals[i] = '0;
  endfunction

  function automatic void accumulate_score(logic [CAND_W-1:0] cand, logic [PASS_W-1:0] pidx,
                                           logic signed [RAW_W-1:0] r,
                                           logic signed [WGT_W-1:0] g);
    logic signed [PROD_W-1:0] prod;
    logic signed [63:0] acc;
    logic signed [63:0] add;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    int slot;
    hi = (64'sd1 <<< (STORE_W - 1)) - 64'sd1;
    lo = -(64'sd1 <<< (STORE_W - 1));
    slot = int'(cand) * SEL_PASSES + int'(pidx);
    prod = r * g;
    acc = score_totals[slot];
    add = prod;
    acc = acc + add;
    if (acc > hi) acc = hi;
    if (acc < lo) acc = lo;
    score_totals[slot] = acc[STORE_W-1:0];
  endfunction

  function automatic verdict_t pick_winner(logic [CNT_W-1:0] count);
    int passes;
    int n;
    int best;
    int left;
    int first;
    bit alive [SEL_CANDS];
    bit have;
    bit settled;
    logic signed [63:0] best_score;
    logic signed [63:0] s;
    logic [63:0] gap;
    verdict_t v;
    v = '0;
    settled = 1'b0;
    passes = (pass_cfg > SEL_PASSES) ? SEL_PASSES : int'(pass_cfg);
    n = (count > SEL_CANDS) ? SEL_CANDS : int'(count);
    for (int i = 0; i < SEL_CANDS; i++) alive[i] = (i < n);
    for (int p = 0; p < passes && !settled; p++) begin
      have = 1'b0;
      best = 0;
      best_score = '0;
      left = 0;
      first = 0;
      for (int i = 0; i < SEL_CANDS; i++) begin
        if (alive[i]) begin
          s = score_totals[i*SEL_PASSES + p];
          if (!have || s > best_score) begin
            have = 1'b1;
            best = i;
            best_score = s;
          end
        end
      end
      if (!have) begin
        settled = 1'b1;
      end else if (p == passes - 1) begin
        v.found = 1'b1;
        v.winner = CAND_W'(best);
        settled = 1'b1;
      end else begin
        for (int i = 0; i < SEL_CANDS; i++) begin
          if (alive[i]) begin
            s = score_totals[i*SEL_PASSES + p];
            gap = best_score - s;
            if (gap > {16'd0, thr_cfg[p]}) begin
              alive[i] = 1'b0;
            end else begin
              if (left == 0) first = i;
              left++;
            end
          end
        end
        if (left == 1) begin
          v.found = 1'b1;
          v.winner = CAND_W'(first);
          settled = 1'b1;
        end
      end
    end
    if (!settled) begin
      for (int i = 0; i < SEL_CANDS; i++) begin
        if (alive[i] && !v.found) begin
          v.found = 1'b1;
          v.winner = CAND_W'(i);
        end
      end
    end
    clear_totals();
    return v;
  endfunction

  task automatic lower_start();
    if (start_up) begin
      start <= 1'b0;
      start_up = 1'b0;
    end
  endtask

  task automatic send_word(score_word_t w, bit typed, verdict_t typed_v);
    verdict_t v;
    candidate <= w.cand;
    pass_number <= w.pidx;
    raw_score <= w.raw;
    weight <= w.wgt;
    candidate_count <= w.count;
    last <= w.last;
    start <= 1'b1;
    start_up = 1'b1;
    do @(posedge clk); while (busy);
    accumulate_score(w.cand, w.pidx, w.raw, w.wgt);
    if (w.last) begin
      v = pick_winner(w.count);
      if (typed) v = typed_v;
      pending_verdicts = {pending_verdicts, v};
    end
    words_sent++;
    phase_words++;
    if (idle_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        lower_start();
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  task automatic write_reg(mpbcs_pkg::reg_idx_t idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 8);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx == mpbcs_pkg::REG_PASS_COUNT) pass_cfg = value[2:0];
    else thr_cfg[int'(idx) - int'(mpbcs_pkg::REG_THR0)] = value[THR_W-1:0];
  endtask

  task automatic write_settings(logic [2:0] pc, logic [THR_W-1:0] t0, logic [THR_W-1:0] t1,
                                logic [THR_W-1:0] t2, logic [THR_W-1:0] t3);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    write_reg(mpbcs_pkg::REG_PASS_COUNT, {noise[63:3], pc});
    noise = {$urandom, $urandom};
    write_reg(mpbcs_pkg::REG_THR0, {noise[63:THR_W], t0});
    noise = {$urandom, $urandom};
    write_reg(mpbcs_pkg::REG_THR1, {noise[63:THR_W], t1});
    noise = {$urandom, $urandom};
    write_reg(mpbcs_pkg::REG_THR2, {noise[63:THR_W], t2});
    noise = {$urandom, $urandom};
    write_reg(mpbcs_pkg::REG_THR3, {noise[63:THR_W], t3});
    settings_count++;
  endtask

  // hold until every selection has reported and the store clear has run out
  task automatic wait_idle();
    lower_start();
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SEL_CANDS * SEL_PASSES + 32) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [THR_W-1:0] pick_threshold();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: return '0;
      1: return THR_MAX;
      4: return r[THR_W-1:0];
      default: return THR_W'($urandom_range(0, 6)) << 24;
    endcase
  endfunction

  function automatic score_word_t noise_word();
    score_word_t w;
    w.cand = CAND_W'($urandom);
    w.pidx = PASS_W'($urandom);
    w.raw = $urandom;
    w.wgt = WGT_W'($urandom);
    w.count = CNT_W'($urandom);
    w.last = 1'b0;
    return w;
  endfunction

  function automatic score_word_t shaped_word(int lim);
    score_word_t w;
    int pick;
    w = noise_word();
    if ($urandom_range(0, 19) != 0) w.cand = CAND_W'($urandom_range(0, lim - 1));
    if ($urandom_range(0, 4) != 0) w.raw = (int'($urandom_range(0, 8)) - 4) * 65536;
    pick = $urandom_range(0, 19);
    if (pick < 14) w.wgt = W1;
    else if (pick < 17) w.wgt = 16'hFF00;
    return w;
  endfunction

  task automatic run_selection();
    score_word_t w;
    logic [CNT_W-1:0] cnt;
    int loads;
    int lim;
    bit noisy;
    noisy = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 9))
      0: cnt = '0;
      1: cnt = CNT_W'(SEL_CANDS);
      2: cnt = CNT_W'($urandom_range(SEL_CANDS + 1, 127));
      default: cnt = CNT_W'($urandom_range(1, 12));
    endcase
    lim = (cnt == 0) ? 1 : ((cnt > SEL_CANDS) ? SEL_CANDS : int'(cnt));
    loads = $urandom_range(0, 14);
    for (int i = 0; i <= loads; i++) begin
      w = noisy ? noise_word() : shaped_word(lim);
      if (i == loads) begin
        w.count = cnt;
        w.last = 1'b1;
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  // drive one slot far past the store range so the sum has to clamp
  task automatic saturate_slot(logic [CAND_W-1:0] cand, bit upward, logic [CNT_W-1:0] cnt);
    score_word_t w;
    for (int i = 0; i < SAT_WORDS; i++) begin
      w.cand = cand;
      w.pidx = '0;
      w.raw = upward ? 32'h8000_0000 + $urandom_range(0, 255)
                     : 32'h7FFF_FFFF - $urandom_range(0, 255);
      w.wgt = 16'h8000 + WGT_W'($urandom_range(0, 15));
      w.count = cnt;
      w.last = (i == SAT_WORDS - 1);
      send_word(w, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && done) begin
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        $error("done: result with no selection pending (found %0b, winner %0d)", found, winner);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, found);
          mismatch_count++;
        end
        if (winner !== want.winner) begin
          $error("winner: expected %0d, got %0d", want.winner, winner);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    dir_row_t row;
    score_word_t w;
    int pc_plan [8];
    pc_plan = '{4, 2, 1, 3, 0, 4, 7, 2};
    rst <= 1'b1;
    start <= 1'b0;
    candidate <= '0;
    pass_number <= '0;
    raw_score <= '0;
    weight <= '0;
    candidate_count <= '0;
    last <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    clear_totals();
    pass_cfg = 3'd1;
    for (int t = 0; t < NUM_THR; t++) thr_cfg[t] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (busy);

    idle_on = 1'b1;
    for (int r = 0; r < $size(dir_rows); r++) begin
      row = dir_rows[r];
      if (row.cfg) begin
        wait_idle();
        write_settings(row.pc, row.thr, row.thr, row.thr, row.thr);
      end
      w.cand = row.cand;
      w.pidx = row.pidx;
      w.raw = row.raw;
      w.wgt = row.wgt;
      w.count = row.count;
      w.last = row.last;
      send_word(w, row.typed, '{row.ef, row.ew});
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_settings(3'(pc_plan[ph]), pick_threshold(), pick_threshold(),
                     pick_threshold(), pick_threshold());
      idle_on = (ph % 3 != 0);
      phase_words = 0;
      while (phase_words < 120) run_selection();
    end

    wait_idle();
    write_settings(3'd1, pick_threshold(), pick_threshold(), pick_threshold(),
                   pick_threshold());
    idle_on = 1'b1;
    saturate_slot(6'd5, 1'b1, 7'd64);
    saturate_slot(6'd0, 1'b0, 7'd2);

    wait_idle();
    $display("testbench: %0d score words sent, %0d selections checked", words_sent,
             verdicts_seen);
    $display("testbench: %0d register settings, saturation driven both ways", settings_count);
    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
